FILE: rtl/mat_pkg.sv
`default_nettype none

package mat_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int CFG_W = 7;

  // defaults
  localparam int MAX_LENGTH_DEF = 64;
  localparam int LEN_RESET = 8;

  // control for the row of sample cells
  typedef struct packed {
    logic clear;  // zero the cell
    logic shift;  // take the neighbour's value
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/mat_cell.sv
`default_nettype none

// One slot of the sample line: holds a sample and hands it on when shifted.
module mat_cell (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire mat_pkg::cell_ctl_t              ctl,
  input  wire logic signed [mat_pkg::SAMPLE_W-1:0] prev_d,
  output logic signed [mat_pkg::SAMPLE_W-1:0]      data_q
);

  logic signed [mat_pkg::SAMPLE_W-1:0] data_r;

  // cleared on reset and on a length write
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      data_r <= '0;
    end else if (ctl.shift) begin
      data_r <= prev_d;
    end
  end

  assign data_q = data_r;

endmodule

`default_nettype wire

FILE: rtl/mat_div.sv
`default_nettype none

// Bit-serial restoring divider: signed dividend, positive divisor,
// quotient truncated toward zero. DIVIDEND_W steps per division.
module mat_div #(
  parameter int DIVIDEND_W = 23,
  parameter int DIVISOR_W  = 7
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire logic signed [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]     divisor,
  output logic                          done,
  output logic signed [DIVIDEND_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] a_r;
  logic [DIVISOR_W-1:0]  d_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic                  neg_r;

  logic [DIVISOR_W:0]    rem_sh;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_nxt;
  logic [DIVIDEND_W-1:0] mag;

  // magnitude of the dividend; the most negative value maps onto itself
  assign mag = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);

  // one quotient bit per step
  always_comb begin
    rem_sh = {rem_r, a_r[DIVIDEND_W-1]};
    ge = (rem_sh >= {1'b0, d_r});
    if (ge) begin
      rem_nxt = DIVISOR_W'(rem_sh - {1'b0, d_r});
    end else begin
      rem_nxt = DIVISOR_W'(rem_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath; quotient bits shift in behind the dividend bits
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= mag;
      d_r   <= divisor;
      rem_r <= '0;
      neg_r <= dividend[DIVIDEND_W-1];
    end else if (busy_r) begin
      a_r   <= {a_r[DIVIDEND_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quotient = neg_r ? $signed(-a_r) : $signed(a_r);

endmodule

`default_nettype wire

FILE: rtl/moving_average_trimmed.sv
// Flow per sample: shift it into the cell row, rotate the row once round for the
//   sum/min/max scan, then run the bit-serial divider for the window average and
//   again for the trimmed average; a window under three skips the second divide.
// A new sample is taken only in idle, once the previous result has gone into the
//   output register; output stalls hold the block.
// Reset (synchronous, rst_n low): cells cleared, window length 8 (or MAX_LENGTH
//   if smaller), no result pending. A length write clears the cells.
`default_nettype none

module moving_average_trimmed #(
  parameter int MAX_LENGTH = mat_pkg::MAX_LENGTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_wr_en,
  input  wire logic [mat_pkg::CFG_W-1:0]       cfg_wr_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire logic signed [mat_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [mat_pkg::SAMPLE_W-1:0]  out_average,
  output logic signed [mat_pkg::SAMPLE_W-1:0]  out_trimmed_average,
  output logic                                 out_trimmed_valid
);

  localparam int SW    = mat_pkg::SAMPLE_W;
  localparam int LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int IDX_W = $clog2(MAX_LENGTH);
  localparam int SUM_W = SW + 1 + $clog2(MAX_LENGTH);
  localparam int RST_LEN = (mat_pkg::LEN_RESET > MAX_LENGTH) ? MAX_LENGTH
                                                             : mat_pkg::LEN_RESET;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SCAN     = 5'b00010,
    S_DIV_AVG  = 5'b00100,
    S_DIV_TRIM = 5'b01000,
    S_OUT      = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [IDX_W-1:0]      idx_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SW-1:0]  min_r, max_r;
  logic                  div_go_r;
  logic signed [SW-1:0]  avg_r;
  logic                  out_valid_r;
  logic signed [SW-1:0]  out_avg_r, out_trim_r;
  logic                  out_tvalid_r;
  logic signed [SW-1:0]  out_trim_hold;

  logic                  in_xfer;
  logic                  out_load;
  logic                  out_free;
  mat_pkg::cell_ctl_t    cell_ctl;
  logic signed [SW-1:0]  cell_q [MAX_LENGTH];
  logic signed [SW-1:0]  head_d;
  logic signed [SW-1:0]  tail;
  logic                  in_win;
  logic                  trim_ok;
  logic signed [SUM_W-1:0] trim_num;
  logic signed [SUM_W-1:0] div_dividend;
  logic [LEN_W-1:0]      div_divisor;
  logic                  div_done;
  logic signed [SUM_W-1:0] div_q;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_OUT) && out_free;

  // effective window length, clamped to 1..MAX_LENGTH
  always_comb begin
    len_nxt = len_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        len_nxt = LEN_W'(1);
      end else if (int'(cfg_wr_data) > MAX_LENGTH) begin
        len_nxt = LEN_W'(MAX_LENGTH);
      end else begin
        len_nxt = LEN_W'(cfg_wr_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(RST_LEN);
    end else begin
      len_r <= len_nxt;
    end
  end

  // row of cells: shift in the sample on transfer, then rotate once round
  assign cell_ctl.clear = cfg_wr_en;
  assign cell_ctl.shift = in_xfer || (state_r == S_SCAN);
  assign tail   = cell_q[MAX_LENGTH-1];
  assign head_d = (state_r == S_IDLE) ? in_sample : tail;

  for (genvar g = 0; g < MAX_LENGTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      mat_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (cell_ctl),
        .prev_d (head_d),
        .data_q (cell_q[g])
      );
    end else begin : g_body
      mat_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (cell_ctl),
        .prev_d (cell_q[g-1]),
        .data_q (cell_q[g])
      );
    end
  end

  // tail holds slot idx_r during the scan; only slots below the length count
  assign in_win  = (LEN_W'(idx_r) < len_r);
  assign trim_ok = (len_r >= LEN_W'(3));

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      idx_r <= IDX_W'(MAX_LENGTH - 1);
      sum_r <= '0;
      min_r <= {1'b0, {(SW-1){1'b1}}};
      max_r <= {1'b1, {(SW-1){1'b0}}};
    end else if (state_r == S_SCAN) begin
      idx_r <= idx_r - 1'b1;
      if (in_win) begin
        sum_r <= sum_r + SUM_W'(tail);
        if (tail < min_r) begin
          min_r <= tail;
        end
        if (tail > max_r) begin
          max_r <= tail;
        end
      end
    end
  end

  // shared divider: window average first, then, for a window of three or more, trimmed average
  assign trim_num     = sum_r - SUM_W'(min_r) - SUM_W'(max_r);
  assign div_dividend = (state_r == S_DIV_TRIM) ? trim_num : sum_r;
  assign div_divisor  = (state_r == S_DIV_TRIM) ? LEN_W'(len_r - LEN_W'(2)) : len_r;

  mat_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r == '0) begin
          state_nxt = S_DIV_AVG;
        end
      end
      S_DIV_AVG: begin
        if (div_done) begin
          state_nxt = trim_ok ? S_DIV_TRIM : S_OUT;
        end
      end
      S_DIV_TRIM: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      div_go_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      div_go_r <= ((state_r == S_SCAN) && (idx_r == '0)) ||
                  ((state_r == S_DIV_AVG) && div_done && trim_ok);
    end
  end

  // result holding
  always_ff @(posedge clk) begin
    if ((state_r == S_DIV_AVG) && div_done) begin
      avg_r <= div_q[SW-1:0];
    end
    if (out_load) begin
      out_avg_r    <= avg_r;
      out_tvalid_r <= trim_ok;
    end
    if ((state_r == S_DIV_TRIM) && div_done) begin
      out_trim_r <= div_q[SW-1:0];
    end else if ((state_r == S_DIV_AVG) && div_done && !trim_ok) begin
      out_trim_r <= '0;
    end
  end

  // result valid: set on load, dropped once the transfer goes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_average         = out_avg_r;
  assign out_trimmed_average = out_trim_hold;
  assign out_trimmed_valid   = out_tvalid_r;

  // trimmed average staged into the output register on load
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_trim_hold <= out_trim_r;
    end
  end

  // checks
  a_state_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");

  a_scan_to_div : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && (idx_r == '0) |=> (state_r == S_DIV_AVG) && div_go_r)
    else $error("scan end did not start the divider");

  a_div_done_state : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_AVG) || (state_r == S_DIV_TRIM))
    else $error("divider finished outside a divide phase");

  a_tvalid_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_trimmed_valid == (len_r >= LEN_W'(3))))
    else $error("trimmed flag disagrees with window length");

endmodule

`default_nettype wire

FILE: dv/moving_average_trimmed_tb.sv
`default_nettype none

module moving_average_trimmed_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W     = mat_pkg::SAMPLE_W;
  localparam int CFG_W        = mat_pkg::CFG_W;
  localparam int LEN_RESET    = mat_pkg::LEN_RESET;
  localparam int RING_DEPTH   = mat_pkg::MAX_LENGTH_DEF;
  localparam int RANDOM_ITEMS = 1900;
  localparam int IDLE_PCT     = 12;
  localparam int HOLD_CYCLES  = 600;   // long receiver hold-off
  localparam int CFG_SETTLE   = 16;    // quiet cycles before a length write
  localparam int DRAIN_CYCLES = 200;   // extra wait after the last expected result
  localparam int STALL_LIMIT  = 5000;  // cycles without any transfer
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic signed [SAMPLE_W-1:0] trimmed;
    logic                       trimmed_ok;
  } avg_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_LENGTH} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    int          value;
    bit          fixed;   // typed-in expectation instead of the predictor
    avg_result_t want;
  } stim_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [CFG_W-1:0]           cfg_wr_data;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_average;
  logic signed [SAMPLE_W-1:0] out_trimmed_average;
  logic                       out_trimmed_valid;

  moving_average_trimmed i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_average         (out_average),
    .out_trimmed_average (out_trimmed_average),
    .out_trimmed_valid   (out_trimmed_valid)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // filter state mirrored by the testbench
  logic signed [SAMPLE_W-1:0] ring_q [RING_DEPTH];
  int unsigned                ring_pos;
  logic signed [22:0]         ring_sum;
  logic [CFG_W-1:0]           win_len;

  avg_result_t expected_q [$];
  stim_row_t   dir_rows [$];

  // sender side tags the typed-in expectation onto the payload
  bit          drv_fixed;
  avg_result_t drv_want;

  bit quiet;      // no idling on either side
  bit hold_req;   // ask the receiver for a long hold-off
  int hold_done;
  int items_sent;
  int results_seen;
  int length_writes;
  int mismatch_cnt;
  int idle_cycles;

  // length 0 behaves as 1, anything over the ring depth as the depth
  function automatic int unsigned active_len();
    if (win_len == '0) return 1;
    if (win_len > RING_DEPTH) return RING_DEPTH;
    return 32'(win_len);
  endfunction

  // a length write clears ring, sum and position
  function automatic void set_window(logic [CFG_W-1:0] v);
    win_len = v;
    foreach (ring_q[k]) ring_q[k] = '0;
    ring_pos = 0;
    ring_sum = '0;
  endfunction

  function automatic avg_result_t filter_step(logic signed [SAMPLE_W-1:0] s);
    int unsigned len;
    int unsigned lo;
    int unsigned hi;
    int          total;
    avg_result_t r;
    len = active_len();
    if (ring_pos >= len) ring_pos = 0;
    ring_sum = ring_sum - ring_q[ring_pos] + s;
    ring_q[ring_pos] = s;
    ring_pos = (ring_pos + 1 >= len) ? 0 : ring_pos + 1;
    total = int'(ring_sum);
    r.average    = SAMPLE_W'(total / int'(len));
    r.trimmed    = '0;
    r.trimmed_ok = 1'b0;
    if (len >= 3) begin
      // first-found min and max; a constant window gives the same slot twice
      lo = 0;
      hi = 0;
      for (int unsigned k = 1; k < len; k++) begin
        if (ring_q[lo] > ring_q[k]) lo = k;
        if (ring_q[hi] < ring_q[k]) hi = k;
      end
      r.trimmed    = SAMPLE_W'((total - int'(ring_q[lo]) - int'(ring_q[hi])) /
                               (int'(len) - 2));
      r.trimmed_ok = 1'b1;
    end
    return r;
  endfunction

  function automatic stim_row_t mk_row(row_kind_t kind, int value, bit fixed,
                                       int avg, int trim, bit ok);
    stim_row_t row;
    row.kind            = kind;
    row.value           = value;
    row.fixed           = fixed;
    row.want.average    = SAMPLE_W'(avg);
    row.want.trimmed    = SAMPLE_W'(trim);
    row.want.trimmed_ok = ok;
    return row;
  endfunction

  // offer one sample and hold it until the transfer
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit fixed,
                             input avg_result_t want);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    drv_fixed <= fixed;
    drv_want  <= want;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  // length writes only once the block has drained
  task automatic write_length(input logic [CFG_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    set_window(v);
    length_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // receiver: random stalls, quiet stretches, one long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        hold_done++;
      end else if (!quiet && $urandom_range(99) < IDLE_PCT) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    avg_result_t pred;
    avg_result_t got;
    avg_result_t want;
    if (rst_n === 1'b1) begin
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        pred = filter_step(in_sample);
        expected_q.push_back(drv_fixed ? drv_want : pred);
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got.average    = out_average;
        got.trimmed    = out_trimmed_average;
        got.trimmed_ok = out_trimmed_valid;
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("%0t: result with nothing expected: avg %0d trim %0d ok %0b",
                     $realtime, $signed(got.average), $signed(got.trimmed),
                     got.trimmed_ok);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
              $display("%0t: result %0d: expected avg %0d trim %0d ok %0b,",
                       $realtime, results_seen, $signed(want.average),
                       $signed(want.trimmed), want.trimmed_ok,
                       " got avg %0d trim %0d ok %0b",
                       $signed(got.average), $signed(got.trimmed), got.trimmed_ok);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $realtime, idle_cycles, expected_q.size());
      $display("moving_average_trimmed regression: fail");
      $finish;
    end
  end

  // directed stimulus then random phases
  initial begin
    int          random_target;
    int          phase;
    int          n_items;
    int          pick;
    logic [CFG_W-1:0]           len_sel;
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] prev_s;
    avg_result_t                no_want;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_sample   = '0;
    drv_fixed   = 1'b0;
    drv_want    = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    idle_cycles = 0;
    no_want     = '0;
    prev_s      = '0;
    set_window(CFG_W'(LEN_RESET));

    // reset-length window, extremes, truncation of a small negative sum
    dir_rows.push_back(mk_row(ROW_SAMPLE, 32767, 1, 4095, 0, 1));
    dir_rows.push_back(mk_row(ROW_SAMPLE, -32768, 1, 0, 0, 1));
    dir_rows.push_back(mk_row(ROW_SAMPLE, -32768, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 21845, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, -21846, 0, 0, 0, 0));
    // short windows: trimmed result held at zero and flagged as not valid
    dir_rows.push_back(mk_row(ROW_LENGTH, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, -32768, 1, -32768, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 32767, 1, 32767, 0, 0));
    dir_rows.push_back(mk_row(ROW_LENGTH, 2, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 32767, 1, 16383, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 32767, 1, 32767, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, -32768, 1, 0, 0, 0));
    // zero length acts as one
    dir_rows.push_back(mk_row(ROW_LENGTH, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, -5, 1, -5, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 7, 1, 7, 0, 0));
    // length three: constant window tie, then wrap round the ring
    dir_rows.push_back(mk_row(ROW_LENGTH, 3, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 100, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 100, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 100, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, -7, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 5, 0, 0, 0, 0));
    // over-range length clamps to the ring depth
    dir_rows.push_back(mk_row(ROW_LENGTH, 127, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, -32768, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 32767, 0, 0, 0, 0));
    // full-depth window
    dir_rows.push_back(mk_row(ROW_LENGTH, 64, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_SAMPLE, 32767, 1, 511, 0, 1));
    dir_rows.push_back(mk_row(ROW_SAMPLE, -1, 0, 0, 0, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LENGTH)
        write_length(CFG_W'(dir_rows[i].value));
      else
        send_sample(SAMPLE_W'(dir_rows[i].value), dir_rows[i].fixed, dir_rows[i].want);
    end

    // random phases, each under a fresh window length
    random_target = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < random_target) begin
      pick = $urandom_range(9);
      case (pick)
        0: begin
          len_sel = '0;
        end
        1: begin
          len_sel = CFG_W'(1);
        end
        2: begin
          len_sel = CFG_W'(2);
        end
        3: begin
          len_sel = CFG_W'(3);
        end
        4: begin
          len_sel = CFG_W'(RING_DEPTH);
        end
        5: begin
          len_sel = '1;
        end
        default: begin
          len_sel = CFG_W'($urandom_range(127));
        end
      endcase
      write_length(len_sel);
      quiet = (phase == 2);
      if (phase == 4) hold_req = 1'b1;
      n_items = (phase == 2) ? 150 : $urandom_range(150, 20);
      repeat (n_items) begin
        // full-range values, small values for ties, extremes, repeats
        pick = $urandom_range(99);
        if (pick < 50)
          s = SAMPLE_W'($urandom);
        else if (pick < 70)
          s = SAMPLE_W'($signed($urandom_range(6)) - 3);
        else if (pick < 80)
          case ($urandom_range(3))
            0: s = 16'sh8000;
            1: s = 16'sh7fff;
            2: s = '0;
            default: s = '1;
          endcase
        else
          s = prev_s;
        prev_s = s;
        send_sample(s, 1'b0, no_want);
      end
      quiet = 1'b0;
      phase++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples over %0d window settings (0, 1, 2, 3, 64, 127 and random)",
             items_sent, length_writes);
    $display("checked %0d results, %0d long receiver hold-off(s), %0d failure(s)",
             results_seen, hold_done, mismatch_cnt + expected_q.size());
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("moving_average_trimmed regression: pass");
    end else begin
      $display("moving_average_trimmed regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
